// ===== hdl/rhht_pkg.sv =====
`default_nettype none
package rhht_pkg;

   localparam int DEFAULT_SLOTS      = 256;
   localparam int DEFAULT_KEY_BITS   = 32;
   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int FILL_NUMERATOR     = 3;
   localparam int FILL_DENOMINATOR   = 4;
   localparam int MAX_ENTRIES_RESET =
      (DEFAULT_SLOTS * FILL_NUMERATOR) / FILL_DENOMINATOR;

   localparam int LIMIT_BITS = 9;
   localparam int TOTAL_BITS = 9;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] key;
      logic [31:0] hash_value;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [31:0]           old_value;
      logic                  full_res;
      logic [TOTAL_BITS-1:0] entry_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_PLACE_RD,
      ST_PLACE_CHK,
      ST_REM_RD,
      ST_REM_CHK,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_CLEAR_STEP,
      DP_LOAD,
      DP_FIND_STEP,
      DP_HIT,
      DP_HIT_UPDATE,
      DP_HIT_REMOVE,
      DP_FULL,
      DP_PLACE_START,
      DP_PLACE_STEP,
      DP_PLACE_FILL,
      DP_REM_STEP,
      DP_REM_END,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       slot_valid;
      logic       key_match;
      logic       probe_stop;
      logic       probe_last;
      logic       shift_stop;
      logic       at_limit;
      logic       clear_last;
      logic       rsp_busy;
   } ctl_status_type;

endpackage
`default_nettype wire

// ===== hdl/rhht_ram.sv =====
`default_nettype none
module rhht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hdl/rhht_ctrl.sv =====
`default_nettype none
module rhht_ctrl
   import rhht_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_NONE;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLEAR_STEP;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_FIND_RD;
            end
         end
         ST_FIND_RD: begin
            if (status.command inside {CMD_LOOKUP, CMD_INSERT, CMD_REMOVE}) begin
               state_in = ST_FIND_CHK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FIND_CHK: begin
            if (status.slot_valid && !status.probe_stop && status.key_match) begin
               case (status.command)
                  CMD_INSERT: cmd.op = DP_HIT_UPDATE;
                  CMD_REMOVE: cmd.op = DP_HIT_REMOVE;
                  default:    cmd.op = DP_HIT;
               endcase
               state_in = (status.command == CMD_REMOVE) ? ST_REM_RD : ST_DONE;
            end else if (status.slot_valid && !status.probe_stop && !status.probe_last) begin
               cmd.op   = DP_FIND_STEP;
               state_in = ST_FIND_RD;
            end else if (status.command == CMD_INSERT) begin
               if (status.at_limit) begin
                  cmd.op   = DP_FULL;
                  state_in = ST_DONE;
               end else begin
                  cmd.op   = DP_PLACE_START;
                  state_in = ST_PLACE_RD;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PLACE_RD: begin
            state_in = ST_PLACE_CHK;
         end
         ST_PLACE_CHK: begin
            if (!status.slot_valid) begin
               cmd.op   = DP_PLACE_FILL;
               state_in = ST_DONE;
            end else begin
               cmd.op   = DP_PLACE_STEP;
               state_in = ST_PLACE_RD;
            end
         end
         ST_REM_RD: begin
            state_in = ST_REM_CHK;
         end
         ST_REM_CHK: begin
            if (status.shift_stop) begin
               cmd.op   = DP_REM_END;
               state_in = ST_DONE;
            end else begin
               cmd.op   = DP_REM_STEP;
               state_in = ST_REM_RD;
            end
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.op   = DP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/rhht_dpath.sv =====
`default_nettype none
module rhht_dpath
   import rhht_pkg::*;
#(
   parameter int SLOTS      = DEFAULT_SLOTS,
   parameter int KEY_BITS   = DEFAULT_KEY_BITS,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [LIMIT_BITS-1:0] csr_wr_data,
   input  wire ctl_cmd_type           cmd,
   output ctl_status_type             status
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
   localparam int E_W   = 1 + 32 + KEY_BITS + VALUE_BITS;

   req_type               req_ff;
   logic [IDX_W-1:0]      pos_ff, prev_ff;
   logic [CNT_W-1:0]      cnt_ff, count_ff;
   logic [LIMIT_BITS-1:0] max_ff;
   logic [31:0]           car_hash_ff;
   logic [KEY_BITS-1:0]   car_key_ff;
   logic [VALUE_BITS-1:0] car_val_ff;
   logic                  hit_ff, full_ff;
   logic [VALUE_BITS-1:0] old_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [E_W-1:0]        wr_data;
   logic [E_W-1:0]        rd_data;

   logic                  rd_valid;
   logic [31:0]           rd_hash;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [KEY_BITS-1:0]   key_w;
   logic [VALUE_BITS-1:0] val_w;
   logic [IDX_W-1:0]      probe_len;
   logic [CNT_W-1:0]      probe_len_ext;
   logic [CMP_W-1:0]      lim;
   logic                  swap;

   rhht_ram #(
      .WIDTH (E_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   assign {rd_valid, rd_hash, rd_key, rd_val} = rd_data;
   assign key_w         = KEY_BITS'(req_ff.key);
   assign val_w         = VALUE_BITS'(req_ff.value_in);
   assign probe_len     = pos_ff - rd_hash[IDX_W-1:0];
   assign probe_len_ext = CNT_W'(probe_len);
   assign swap          = (cnt_ff > probe_len_ext);
   assign lim      = (CMP_W'(max_ff) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(max_ff);

   always_comb begin
      status.command    = req_ff.command;
      status.slot_valid = rd_valid;
      status.key_match  = (rd_hash == req_ff.hash_value) && (rd_key == key_w);
      status.probe_stop = swap;
      status.probe_last = (cnt_ff == CNT_W'(SLOTS - 1));
      status.shift_stop = !rd_valid || (probe_len == '0) || (cnt_ff == CNT_W'(SLOTS));
      status.at_limit   = (CMP_W'(count_ff) >= lim);
      status.clear_last = (cnt_ff == CNT_W'(SLOTS - 1));
      status.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = '0;
      case (cmd.op)
         DP_CLEAR_STEP: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
         end
         DP_HIT_UPDATE: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, rd_hash, rd_key, val_w};
         end
         DP_PLACE_FILL: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, car_hash_ff, car_key_ff, car_val_ff};
         end
         DP_PLACE_STEP: begin
            wr_en   = swap;
            wr_data = {1'b1, car_hash_ff, car_key_ff, car_val_ff};
         end
         DP_REM_STEP: begin
            wr_en   = 1'b1;
            wr_addr = prev_ff;
            wr_data = {1'b1, rd_hash, rd_key, rd_val};
         end
         DP_REM_END: begin
            wr_en   = 1'b1;
            wr_addr = prev_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         count_ff     <= '0;
         max_ff       <= LIMIT_BITS'(MAX_ENTRIES_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (cmd.op == DP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            DP_CLEAR_STEP: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            DP_LOAD: begin
               req_ff  <= req_data;
               pos_ff  <= req_data.hash_value[IDX_W-1:0];
               cnt_ff  <= '0;
               hit_ff  <= 1'b0;
               old_ff  <= '0;
               full_ff <= 1'b0;
            end
            DP_FIND_STEP: begin
               pos_ff <= pos_ff + 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
            end
            DP_HIT, DP_HIT_UPDATE: begin
               hit_ff <= 1'b1;
               old_ff <= rd_val;
            end
            DP_HIT_REMOVE: begin
               hit_ff  <= 1'b1;
               old_ff  <= rd_val;
               prev_ff <= pos_ff;
               pos_ff  <= pos_ff + 1'b1;
               cnt_ff  <= CNT_W'(1);
            end
            DP_FULL: begin
               full_ff <= 1'b1;
            end
            DP_PLACE_START: begin
               pos_ff      <= req_ff.hash_value[IDX_W-1:0];
               cnt_ff      <= '0;
               car_hash_ff <= req_ff.hash_value;
               car_key_ff  <= key_w;
               car_val_ff  <= val_w;
            end
            DP_PLACE_STEP: begin
               if (swap) begin
                  car_hash_ff <= rd_hash;
                  car_key_ff  <= rd_key;
                  car_val_ff  <= rd_val;
                  cnt_ff      <= probe_len_ext + 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               pos_ff <= pos_ff + 1'b1;
            end
            DP_PLACE_FILL: begin
               count_ff <= count_ff + 1'b1;
            end
            DP_REM_STEP: begin
               prev_ff <= pos_ff;
               pos_ff  <= pos_ff + 1'b1;
               cnt_ff  <= cnt_ff + 1'b1;
            end
            DP_REM_END: begin
               count_ff <= count_ff - 1'b1;
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_RESULT) begin
         rsp_data_ff.hit         <= hit_ff;
         rsp_data_ff.old_value   <= 32'(old_ff);
         rsp_data_ff.full_res    <= full_ff;
         rsp_data_ff.entry_total <= TOTAL_BITS'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/robin_hood_hash_table.sv =====
// A lookup probes slot by slot from the home slot until it can respond; an insert of a new
// key then walks again from the home slot up to the empty slot, a remove shifts slots back.
// Requests are taken one at a time, each probe step waiting on the
// registered read of the slot RAM with one read per probe step; a stalled response holds.
// Reset: synchronous; the slot RAM is then swept clear slot by slot, during which
// requests stall and csr writes are taken. SLOTS must be a power of two.
`default_nettype none
module robin_hood_hash_table
   import rhht_pkg::*;
#(
   parameter int SLOTS      = DEFAULT_SLOTS,
   parameter int KEY_BITS   = DEFAULT_KEY_BITS,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [LIMIT_BITS-1:0] csr_wr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   rhht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rhht_dpath #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire
